/* hdl/lrl_pkg.sv */
`timescale 1ns / 1ps
// Package for the LRU recency list: default sizes, register width, operation codes
// and the control struct that is broadcast to every cell of the chain.
// No dependencies.
package lrl_pkg;

    localparam int DEPTH_DEF    = 16;
    localparam int KEY_BITS_DEF = 16;

    localparam int              CAP_W     = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic OP_ACCESS = 1'b0;
    localparam logic OP_DUMP   = 1'b1;

    typedef struct packed {
        logic update;
        logic hit;
    } cell_ctl_t;

endpackage

/* hdl/lrl_cell.sv */
`timescale 1ns / 1ps
// One position of the recency chain: holds a key, compares it with the lookup key
// and takes the key of its front neighbor when the list moves back.
// Depends on lrl_pkg.
module lrl_cell #(
    parameter int KEY_BITS = lrl_pkg::KEY_BITS_DEF
) (
    input  logic                clk,
    input  lrl_pkg::cell_ctl_t  ctl,
    input  logic                in_use,
    input  logic [KEY_BITS-1:0] lookup_key,
    input  logic [KEY_BITS-1:0] prev_key,
    input  logic                match_in,
    output logic                match,
    output logic                match_out,
    output logic [KEY_BITS-1:0] key_q
);
    import lrl_pkg::*;

    logic [KEY_BITS-1:0] key_reg;
    logic                shift;

    assign match     = in_use && (key_reg == lookup_key);
    assign match_out = match | match_in;
    // move back on a miss, or on a hit at or behind this position
    assign shift     = ctl.update & (~ctl.hit | match_out);
    assign key_q     = key_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            key_reg <= prev_key;
        end
    end

endmodule

/* hdl/lru_recency_list.sv */
`timescale 1ns / 1ps
// Top level of the LRU recency list: chain of key cells, occupancy and capacity
// registers, dump sequencer and registered result port.
// Depends on lrl_pkg and lrl_cell.
//
// Usage:
//   An item is taken when start is high and busy is low. operation selects an
//   access of key or a dump of the list. Each result appears on the result
//   ports for one cycle with done high; the receiver cannot stall it.
//   Access: one result in the cycle after the item is taken, with hit,
//   hit_position, evicted_valid/evicted_key and occupancy; last is high.
//   Accesses are taken every cycle (busy stays low); all cells compare, and
//   those that move back shift, in the same cycle.
//   Dump: one result per held key, most recent first, one per cycle; the item
//   first sets the sequencer state, then each key passes through the result
//   registers. last marks the final one. busy is high while the sequencer
//   walks the list. An empty list gives one result with listed_valid low,
//   in the cycle after the item is taken.
//   capacity is written via cfg_write/cfg_data only while idle, a rule for the user
//   that the block does not enforce; 0 acts as 1, values above DEPTH act as DEPTH.
//   Reset empties the list, sets capacity to 16 and stops any dump.
module lru_recency_list #(
    parameter int DEPTH    = lrl_pkg::DEPTH_DEF,
    parameter int KEY_BITS = lrl_pkg::KEY_BITS_DEF
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        cfg_write,
    input  logic [lrl_pkg::CAP_W-1:0]                   cfg_data,
    input  logic                                        start,
    output logic                                        busy,
    input  logic                                        operation,
    input  logic [KEY_BITS-1:0]                         key,
    output logic                                        done,
    output logic                                        hit,
    output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] hit_position,
    output logic                                        evicted_valid,
    output logic [KEY_BITS-1:0]                         evicted_key,
    output logic [$clog2(DEPTH+1)-1:0]                  occupancy,
    output logic                                        listed_valid,
    output logic [KEY_BITS-1:0]                         listed_key,
    output logic                                        last
);
    import lrl_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH+1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    logic [CAP_W-1:0]    cap_reg;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                dumping_reg, dumping_next;
    logic [IDX_W-1:0]    dump_idx_reg, dump_idx_next;

    logic                done_reg, done_next;
    logic                hit_reg, hit_next;
    logic [IDX_W-1:0]    pos_reg, pos_next;
    logic                ev_reg, ev_next;
    logic [KEY_BITS-1:0] evkey_reg, evkey_next;
    logic [CNT_W-1:0]    occ_reg, occ_next;
    logic                lv_reg, lv_next;
    logic [KEY_BITS-1:0] lkey_reg, lkey_next;
    logic                last_reg, last_next;

    logic                accept, do_access, do_dump, list_empty, evict, lookup_hit;
    logic [CMP_W-1:0]    cap_ext, eff_cap;
    logic [CNT_W-1:0]    cnt_m1;
    logic [IDX_W-1:0]    tail_idx, hit_idx;
    logic                dump_last;
    cell_ctl_t           ctl;

    logic [DEPTH:0]      match_chain;
    logic [DEPTH-1:0]    match_vec;
    logic [KEY_BITS-1:0] key_q [DEPTH];

    assign busy       = dumping_reg;
    assign accept     = start & ~busy;
    assign do_access  = accept & (operation == OP_ACCESS);
    assign do_dump    = accept & (operation == OP_DUMP);
    assign list_empty = (count_reg == '0);

    assign match_chain[DEPTH] = 1'b0;
    assign lookup_hit         = match_chain[0];
    assign ctl.update         = do_access;
    assign ctl.hit            = lookup_hit;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic [KEY_BITS-1:0] prev;
            if (gi == 0)
            begin : g_front
                assign prev = key;
            end
            else
            begin : g_rest
                assign prev = key_q[gi-1];
            end
            lrl_cell #(
                .KEY_BITS (KEY_BITS)
            ) u_cell (
                .clk        (clk),
                .ctl        (ctl),
                .in_use     (CNT_W'(gi) < count_reg),
                .lookup_key (key),
                .prev_key   (prev),
                .match_in   (match_chain[gi+1]),
                .match      (match_vec[gi]),
                .match_out  (match_chain[gi]),
                .key_q      (key_q[gi])
            );
        end
    endgenerate

    always_comb
    begin
        hit_idx = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (match_vec[i])
            begin
                hit_idx = hit_idx | IDX_W'(i);
            end
        end
    end

    assign cap_ext  = CMP_W'(cap_reg);
    assign eff_cap  = (cap_reg == '0) ? CMP_W'(1) :
                      ((cap_ext > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : cap_ext);
    assign cnt_m1   = count_reg - CNT_W'(1);
    assign tail_idx = cnt_m1[IDX_W-1:0];
    assign evict    = ~lookup_hit & (CMP_W'(count_reg) >= eff_cap);
    assign dump_last = (dump_idx_reg == tail_idx);

    always_comb
    begin
        count_next    = count_reg;
        dumping_next  = dumping_reg;
        dump_idx_next = dump_idx_reg;
        done_next     = 1'b0;
        hit_next      = 1'b0;
        pos_next      = '0;
        ev_next       = 1'b0;
        evkey_next    = '0;
        occ_next      = count_reg;
        lv_next       = 1'b0;
        lkey_next     = '0;
        last_next     = 1'b1;

        if (dumping_reg)
        begin
            done_next     = 1'b1;
            lv_next       = 1'b1;
            lkey_next     = key_q[dump_idx_reg];
            last_next     = dump_last;
            dump_idx_next = dump_idx_reg + IDX_W'(1);
            if (dump_last)
            begin
                dumping_next = 1'b0;
            end
        end
        else if (do_access)
        begin
            done_next = 1'b1;
            hit_next  = lookup_hit;
            pos_next  = hit_idx;
            ev_next   = evict;
            if (evict)
            begin
                evkey_next = key_q[tail_idx];
            end
            if (!lookup_hit && !evict)
            begin
                count_next = count_reg + CNT_W'(1);
            end
            occ_next = count_next;
        end
        else if (do_dump)
        begin
            if (list_empty)
            begin
                done_next = 1'b1;
            end
            else
            begin
                dumping_next  = 1'b1;
                dump_idx_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg     <= CAP_RESET;
            count_reg   <= '0;
            dumping_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                cap_reg <= cfg_data;
            end
            count_reg   <= count_next;
            dumping_reg <= dumping_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dump_idx_reg <= dump_idx_next;
        if (done_next)
        begin
            hit_reg   <= hit_next;
            pos_reg   <= pos_next;
            ev_reg    <= ev_next;
            evkey_reg <= evkey_next;
            occ_reg   <= occ_next;
            lv_reg    <= lv_next;
            lkey_reg  <= lkey_next;
            last_reg  <= last_next;
        end
    end

    assign done          = done_reg;
    assign hit           = hit_reg;
    assign hit_position  = pos_reg;
    assign evicted_valid = ev_reg;
    assign evicted_key   = evkey_reg;
    assign occupancy     = occ_reg;
    assign listed_valid  = lv_reg;
    assign listed_key    = lkey_reg;
    assign last          = last_reg;

endmodule

/* sim/lru_order_checker.sv */
`timescale 1ns / 1ps
// Checker for the LRU recency list: watches items, register writes and results,
// keeps its own recency order and compares every result field by field.
// Depends on lrl_pkg.
module lru_order_checker (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [lrl_pkg::CAP_W-1:0] cfg_data,
    input  logic                      start,
    input  logic                      busy,
    input  logic                      operation,
    input  logic [15:0]               key,
    input  logic                      done,
    input  logic                      hit,
    input  logic [3:0]                hit_position,
    input  logic                      evicted_valid,
    input  logic [15:0]               evicted_key,
    input  logic [4:0]                occupancy,
    input  logic                      listed_valid,
    input  logic [15:0]               listed_key,
    input  logic                      last,
    output int                        errors,
    output int                        pending
);

    localparam int SLOTS = 16;

    typedef struct packed {
        logic        hit;
        logic [3:0]  pos;
        logic        ev_valid;
        logic [15:0] ev_key;
        logic [4:0]  occ;
        logic        lst_valid;
        logic [15:0] lst_key;
        logic        last;
    } lru_result_t;

    lru_result_t                expected_results[$];
    logic [15:0]                recency[SLOTS];
    int                         held;
    logic [lrl_pkg::CAP_W-1:0]  capacity_reg;

    function automatic int usable_capacity();
        if (capacity_reg == 0)
            return 1;
        if (capacity_reg > SLOTS)
            return SLOTS;
        return int'(capacity_reg);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] lru mismatch: %s", $realtime, msg);
        errors++;
    endtask

    task automatic predict_item(input logic op, input logic [15:0] k);
        lru_result_t r;
        int          pos;
        int          n;
        if (op == lrl_pkg::OP_DUMP)
        begin
            if (held == 0)
            begin
                r      = '0;
                r.last = 1'b1;
                expected_results.push_back(r);
            end
            else
            begin
                for (int i = 0; i < held; i++)
                begin
                    r           = '0;
                    r.occ       = 5'(held);
                    r.lst_valid = 1'b1;
                    r.lst_key   = recency[i];
                    r.last      = (i == held - 1);
                    expected_results.push_back(r);
                end
            end
        end
        else
        begin
            pos = -1;
            for (int i = 0; i < held; i++)
                if (pos < 0 && recency[i] == k)
                    pos = i;
            r      = '0;
            r.last = 1'b1;
            if (pos >= 0)
            begin
                r.hit = 1'b1;
                r.pos = 4'(pos);
                for (int i = pos; i > 0; i--)
                    recency[i] = recency[i-1];
                recency[0] = k;
            end
            else
            begin
                n = held;
                if (n >= usable_capacity())
                begin
                    r.ev_valid = 1'b1;
                    r.ev_key   = recency[n-1];
                    n--;
                end
                for (int i = n; i > 0; i--)
                    recency[i] = recency[i-1];
                recency[0] = k;
                held       = n + 1;
            end
            r.occ = 5'(held);
            expected_results.push_back(r);
        end
    endtask

    task automatic compare_result();
        lru_result_t want;
        if (expected_results.size() == 0)
        begin
            report_mismatch("result with nothing expected");
            return;
        end
        want = expected_results.pop_front();
        if (hit !== want.hit)
            report_mismatch($sformatf("hit got %0h want %0h", hit, want.hit));
        if (hit_position !== want.pos)
            report_mismatch($sformatf("hit_position got %0d want %0d", hit_position, want.pos));
        if (evicted_valid !== want.ev_valid)
            report_mismatch($sformatf("evicted_valid got %0h want %0h",
                                      evicted_valid, want.ev_valid));
        if (evicted_key !== want.ev_key)
            report_mismatch($sformatf("evicted_key got %h want %h", evicted_key, want.ev_key));
        if (occupancy !== want.occ)
            report_mismatch($sformatf("occupancy got %0d want %0d", occupancy, want.occ));
        if (listed_valid !== want.lst_valid)
            report_mismatch($sformatf("listed_valid got %0h want %0h",
                                      listed_valid, want.lst_valid));
        if (listed_key !== want.lst_key)
            report_mismatch($sformatf("listed_key got %h want %h", listed_key, want.lst_key));
        if (last !== want.last)
            report_mismatch($sformatf("last got %0h want %0h", last, want.last));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held         = 0;
            capacity_reg = lrl_pkg::CAP_RESET;
            expected_results.delete();
        end
        else
        begin
            if (done === 1'b1)
                compare_result();
            if (cfg_write)
                capacity_reg = cfg_data;
            if (start && !busy)
                predict_item(operation, key);
        end
        pending = expected_results.size();
    end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// Top of the LRU recency list testbench: clock, reset, item and register stimulus,
// and the final verdict.
// Depends on lrl_pkg, lru_recency_list and lru_order_checker.
module tb_top;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_write;
    logic [lrl_pkg::CAP_W-1:0] cfg_data;
    logic                      start;
    logic                      busy;
    logic                      operation;
    logic [15:0]               key;
    logic                      done;
    logic                      hit;
    logic [3:0]                hit_position;
    logic                      evicted_valid;
    logic [15:0]               evicted_key;
    logic [4:0]                occupancy;
    logic                      listed_valid;
    logic [15:0]               listed_key;
    logic                      last;
    int                        errors;
    int                        pending;

    lru_recency_list i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_data      (cfg_data),
        .start         (start),
        .busy          (busy),
        .operation     (operation),
        .key           (key),
        .done          (done),
        .hit           (hit),
        .hit_position  (hit_position),
        .evicted_valid (evicted_valid),
        .evicted_key   (evicted_key),
        .occupancy     (occupancy),
        .listed_valid  (listed_valid),
        .listed_key    (listed_key),
        .last          (last)
    );

    lru_order_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_data      (cfg_data),
        .start         (start),
        .busy          (busy),
        .operation     (operation),
        .key           (key),
        .done          (done),
        .hit           (hit),
        .hit_position  (hit_position),
        .evicted_valid (evicted_valid),
        .evicted_key   (evicted_key),
        .occupancy     (occupancy),
        .listed_valid  (listed_valid),
        .listed_key    (listed_key),
        .last          (last),
        .errors        (errors),
        .pending       (pending)
    );

    initial
        clk = 1'b0;

    always #1 clk = ~clk;

    initial
    begin
        #1_000_000;
        $display("lru_recency_list verification failed");
        $finish;
    end

    // hold the item until it is taken
    task automatic send_item(input logic op, input logic [15:0] k);
        start     <= 1'b1;
        operation <= op;
        key       <= k;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic pause_sender(input int cycles);
        if (cycles > 0)
        begin
            start <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(negedge clk);
        while (pending != 0 || busy)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [lrl_pkg::CAP_W-1:0] value);
        drain();
        cfg_write <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic run_phase(input logic [lrl_pkg::CAP_W-1:0] cap_value, input int items);
        int          span;
        int          left;
        int          burst;
        int          pick;
        logic [15:0] pool_base;
        write_capacity(cap_value);
        span      = (cap_value == 0) ? 1 : ((cap_value > 16) ? 16 : int'(cap_value));
        span      = span + $urandom_range(1, 4);
        pool_base = 16'($urandom);
        left      = items;
        while (left > 0)
        begin
            burst = $urandom_range(1, 12);
            for (int i = 0; i < burst && left > 0; i++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 10)
                    send_item(lrl_pkg::OP_DUMP, 16'($urandom));
                else if (pick < 25)
                    send_item(lrl_pkg::OP_ACCESS, 16'($urandom));
                else
                    send_item(lrl_pkg::OP_ACCESS, pool_base + 16'($urandom_range(0, span)));
                left--;
            end
            if ($urandom_range(0, 2) != 0)
                pause_sender($urandom_range(1, 6));
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_write = 1'b0;
        cfg_data  = '0;
        start     = 1'b0;
        operation = lrl_pkg::OP_ACCESS;
        key       = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_capacity(5'd16);
        send_item(lrl_pkg::OP_DUMP, 16'h0000);
        for (int i = 0; i < 16; i++)
            send_item(lrl_pkg::OP_ACCESS,
                      (i == 0) ? 16'h0000 : (i == 1) ? 16'hFFFF :
                      (i == 2) ? 16'hAAAA : (i == 3) ? 16'h5555 : 16'h0100 + 16'(i));
        send_item(lrl_pkg::OP_ACCESS, 16'h0000);
        send_item(lrl_pkg::OP_ACCESS, 16'h0000);
        send_item(lrl_pkg::OP_ACCESS, 16'h1234);
        send_item(lrl_pkg::OP_DUMP, 16'hFFFF);
        write_capacity(5'd2);
        send_item(lrl_pkg::OP_ACCESS, 16'hBEEF);
        send_item(lrl_pkg::OP_DUMP, 16'h0000);

        run_phase(5'd1, 60);
        run_phase(5'd0, 50);
        run_phase(5'd31, 70);
        run_phase(5'd3, 60);
        run_phase(5'd16, 80);
        run_phase(5'($urandom_range(1, 16)), 60);

        drain();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("lru_recency_list verification clean");
        else
            $display("lru_recency_list verification failed");
        $finish;
    end

endmodule
